### sv/siphash_1_2_stream_top_macros.svh
// ----------------------------------------------------------------------------
// SipHash-1-2 stream: assertion macros
// Concurrent assertion helpers. They compile to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef SIPHASH_1_2_STREAM_TOP_MACROS_SVH
`define SIPHASH_1_2_STREAM_TOP_MACROS_SVH

`ifndef SYNTH
// Check a property on every rising clock edge outside reset
`define SH12_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("sh12 assertion failed");
// Check that a condition never holds outside reset
`define SH12_ASSERT_NEVER(lbl, clk, rstn, cond) \
  `SH12_ASSERT(lbl, clk, rstn, !(cond))
`else
`define SH12_ASSERT(lbl, clk, rstn, prop)
`define SH12_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

### sv/sh12_pkg.sv
// ----------------------------------------------------------------------------
// SipHash-1-2 stream: shared package
// Lane and command types, init constants and the SipRound function.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sh12_pkg;

  // Lane init constants
  localparam logic [63:0] INIT_A = 64'h736f6d6570736575;
  localparam logic [63:0] INIT_B = 64'h646f72616e646f6d;
  localparam logic [63:0] INIT_C = 64'h6c7967656e657261;
  localparam logic [63:0] INIT_D = 64'h7465646279746573;

  // Value folded into lane c before finalization
  localparam logic [63:0] FINAL_MARK = 64'h00000000000000ff;

  // Configuration register indexes
  localparam logic CFG_KEY_LOW  = 1'b0;
  localparam logic CFG_KEY_HIGH = 1'b1;

  typedef struct packed {
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] c;
    logic [63:0] d;
  } lanes_t;

  // One queued command: optional full word, optional tail with finalization
  typedef struct packed {
    logic        start;     // load lanes from the key first
    logic        has_word;  // compress a full word
    logic        is_final;  // compress tail, finalize, give digest
    logic [63:0] word;
    logic [63:0] tail;
  } cmd_t;

  // Back-end status seen by the top level
  typedef struct packed {
    logic mid;         // inside a multi-cycle command
    logic done_final;  // digest written this cycle
  } back_stat_t;

  function automatic logic [63:0] rotl64(logic [63:0] x, int unsigned r);
    return (x << r) | (x >> (64 - r));
  endfunction

  function automatic lanes_t sip_round(lanes_t v);
    lanes_t t;
    t = v;
    t.a = t.a + t.b; t.b = rotl64(t.b, 13); t.b = t.b ^ t.a;
    t.a = rotl64(t.a, 32);
    t.c = t.c + t.d; t.d = rotl64(t.d, 16); t.d = t.d ^ t.c;
    t.a = t.a + t.d; t.d = rotl64(t.d, 21); t.d = t.d ^ t.a;
    t.c = t.c + t.b; t.b = rotl64(t.b, 17); t.b = t.b ^ t.c;
    t.c = rotl64(t.c, 32);
    return t;
  endfunction

  // Fold a word into lane d, run one round, fold it into lane a
  function automatic lanes_t sip_compress(lanes_t v, logic [63:0] m);
    lanes_t t;
    t = v;
    t.d = t.d ^ m;
    t = sip_round(t);
    t.a = t.a ^ m;
    return t;
  endfunction

endpackage

### sv/sh12_front.sv
// ----------------------------------------------------------------------------
// SipHash-1-2 stream: front end
// Accepts items, tracks message start and length, builds tail blocks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sh12_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [63:0]    message_word_i,
  input  logic [3:0]     byte_count_i,
  input  logic           last_word_i,
  output logic           push_o,
  output sh12_pkg::cmd_t cmd_o,
  input  logic           q_ready_i
);
  import sh12_pkg::*;

  logic        open_q, open_d;
  logic [7:0]  len_q, len_d;
  logic [7:0]  len_base;
  logic [7:0]  len_new;
  logic [3:0]  cnt;
  logic [63:0] masked;

  assign in_ready_o = q_ready_i;
  assign push_o     = in_valid_i && q_ready_i;

  // Saturate the byte count at a full word
  assign cnt      = byte_count_i[3] ? 4'd8 : byte_count_i;
  assign len_base = open_q ? len_q : 8'd0;
  assign len_new  = len_base + (last_word_i ? {4'd0, cnt} : 8'd8);

  // Keep only the valid bytes of a partial word
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      masked[8*i +: 8] = (4'(i) < cnt) ? message_word_i[8*i +: 8] : 8'd0;
    end
  end

  // Classify the item into a command
  always_comb begin
    cmd_o.start    = !open_q;
    cmd_o.word     = message_word_i;
    cmd_o.has_word = !last_word_i || (cnt == 4'd8);
    cmd_o.is_final = last_word_i;
    cmd_o.tail     = {len_new, (cnt == 4'd8) ? 56'd0 : masked[55:0]};
    open_d         = open_q;
    len_d          = len_q;
    if (push_o) begin
      open_d = !last_word_i;
      len_d  = len_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
      len_q  <= 8'd0;
    end else begin
      open_q <= open_d;
      len_q  <= len_d;
    end
  end

endmodule

### sv/sh12_queue.sv
// ----------------------------------------------------------------------------
// SipHash-1-2 stream: command queue
// Small FIFO that decouples the front end from the round engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sh12_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  sh12_pkg::cmd_t cmd_i,
  output logic           ready_o,
  output logic           valid_o,
  output sh12_pkg::cmd_t cmd_o,
  input  logic           pop_i
);
  import sh12_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

  cmd_t          mem_q [DEPTH];
  logic [PW-1:0] wr_q, wr_d;
  logic [PW-1:0] rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;

  assign ready_o = (cnt_q != FULL_CNT);
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rd_q];

  // Advance pointers and occupancy
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == LAST_SLOT) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == LAST_SLOT) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

endmodule

### sv/sh12_back.sv
// ----------------------------------------------------------------------------
// SipHash-1-2 stream: round engine
// Runs one compression or finalization round per cycle unless stalled; holds the digest.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sh12_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [63:0]          key_low_i,
  input  logic [63:0]          key_high_i,
  input  logic                 cmd_valid_i,
  input  sh12_pkg::cmd_t       cmd_i,
  output logic                 cmd_pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [63:0]          digest_o,
  output sh12_pkg::back_stat_t stat_o
);
  import sh12_pkg::*;

  // Phases of one command
  localparam logic [1:0] PH_WORD = 2'd0;
  localparam logic [1:0] PH_TAIL = 2'd1;
  localparam logic [1:0] PH_FIN1 = 2'd2;
  localparam logic [1:0] PH_FIN2 = 2'd3;

  lanes_t      lanes_q, lanes_d;
  lanes_t      init_v;
  lanes_t      src;
  lanes_t      res;
  logic [1:0]  ph_q, ph_d;
  logic [1:0]  ph;
  logic        mid_q, mid_d;
  logic        out_valid_q, out_valid_d;
  logic [63:0] digest_q, digest_d;
  logic [63:0] m;
  logic        last_cycle;
  logic        need_out;
  logic        adv;

  assign init_v = '{a: key_low_i ^ INIT_A, b: key_high_i ^ INIT_B,
                    c: key_low_i ^ INIT_C, d: key_high_i ^ INIT_D};

  // Pick the phase: a fresh command starts at its first step
  assign ph = mid_q ? ph_q : (cmd_i.has_word ? PH_WORD : PH_TAIL);

  always_comb begin
    unique case (ph)
      PH_WORD: last_cycle = !cmd_i.is_final;
      PH_TAIL: last_cycle = 1'b0;
      PH_FIN1: last_cycle = 1'b0;
      PH_FIN2: last_cycle = 1'b1;
    endcase
  end

  assign need_out = last_cycle && cmd_i.is_final;
  assign adv      = cmd_valid_i && (!need_out || !out_valid_q || out_ready_i);

  // Run one round on the current lanes
  always_comb begin
    src = (!mid_q && cmd_i.start) ? init_v : lanes_q;
    unique case (ph)
      PH_WORD: m = cmd_i.word;
      PH_TAIL: m = cmd_i.tail;
      PH_FIN1: m = 64'd0;
      PH_FIN2: m = 64'd0;
    endcase
    res = sip_compress(src, m);
    if (ph == PH_TAIL) begin
      res.c = res.c ^ FINAL_MARK;
    end
  end

  // Advance the sequence and load the output register
  always_comb begin
    lanes_d     = lanes_q;
    ph_d        = ph_q;
    mid_d       = mid_q;
    digest_d    = digest_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (adv) begin
      lanes_d = res;
      mid_d   = !last_cycle;
      ph_d    = ph + 2'd1;
      if (need_out) begin
        digest_d    = res.a ^ res.b ^ res.c ^ res.d;
        out_valid_d = 1'b1;
      end
    end
  end

  assign cmd_pop_o         = adv && last_cycle;
  assign out_valid_o       = out_valid_q;
  assign digest_o          = digest_q;
  assign stat_o.mid        = mid_q;
  assign stat_o.done_final = adv && need_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lanes_q     <= '0;
      ph_q        <= PH_WORD;
      mid_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      lanes_q     <= lanes_d;
      ph_q        <= ph_d;
      mid_q       <= mid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    digest_q <= digest_d;
  end

endmodule

### sv/siphash_1_2_stream_top.sv
// ----------------------------------------------------------------------------
// SipHash-1-2 stream: top level
// Full words: one item per cycle while the queue has room, one SipRound each in the round engine.
// Last item: with eight bytes the engine compresses the word, then the tail
// block, then runs phases FIN1 and FIN2, one SipRound each; digest registered.
// Reset clears key registers, lanes, length and the open-message flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "siphash_1_2_stream_top_macros.svh"

module siphash_1_2_stream_top #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] message_word_i,
  input  logic [3:0]  byte_count_i,
  input  logic        last_word_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] digest_o,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [63:0] cfg_wdata_i
);
  import sh12_pkg::*;

  logic [63:0] key_low_q;
  logic [63:0] key_high_q;
  logic        q_push;
  logic        q_ready;
  logic        q_valid;
  logic        q_pop;
  cmd_t        f_cmd;
  cmd_t        q_cmd;
  back_stat_t  b_stat;

  // Hold key registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q  <= '0;
      key_high_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_KEY_LOW:  key_low_q  <= cfg_wdata_i;
        CFG_KEY_HIGH: key_high_q <= cfg_wdata_i;
      endcase
    end
  end

  sh12_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .message_word_i (message_word_i),
    .byte_count_i   (byte_count_i),
    .last_word_i    (last_word_i),
    .push_o         (q_push),
    .cmd_o          (f_cmd),
    .q_ready_i      (q_ready)
  );

  sh12_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (f_cmd),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .cmd_o   (q_cmd),
    .pop_i   (q_pop)
  );

  sh12_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .key_low_i   (key_low_q),
    .key_high_i  (key_high_q),
    .cmd_valid_i (q_valid),
    .cmd_i       (q_cmd),
    .cmd_pop_o   (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .digest_o    (digest_o),
    .stat_o      (b_stat)
  );

  // A command being worked on stays at the queue head
  `SH12_ASSERT(a_mid_has_cmd, clk_i, rst_ni, b_stat.mid |-> q_valid)
  // A finished digest shows on the output next cycle
  `SH12_ASSERT(a_done_shows, clk_i, rst_ni, b_stat.done_final |=> out_valid_o)
  // Never overwrite a digest that is still waiting
  `SH12_ASSERT_NEVER(a_no_overwrite, clk_i, rst_ni,
                     b_stat.done_final && out_valid_o && !out_ready_i)

endmodule
